FILE: rtl/core/bnf_pkg.sv
// shared constants and codes for the batch normalization forward core
package bnf_pkg;

	localparam int CHANNELS_DEF  = 64;
	localparam int MAX_BATCH_DEF = 4096;

	localparam int DATA_W    = 32;
	localparam int VAR_W     = 31;
	localparam int SUM_W     = 48;
	localparam int SQ_W      = 64;
	localparam int EPS_W     = 17;
	localparam int DEC_W     = 17;
	localparam int CH_W      = 6;
	localparam int ACT_W     = 3;
	localparam int CFG_IDX_W = 3;

	localparam int RAD_W       = 48;
	localparam int SQRT_STEPS  = RAD_W / 2;
	localparam int DIV_STEPS   = 64;
	localparam int IT_W        = 7;

	localparam logic [ACT_W-1:0] ACT_LOAD  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ACCUM = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CLOSE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_NORM  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_TRAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MBU   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EPS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FGAM  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FBET  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY = 3'd6;

	localparam logic [EPS_W-1:0]  EPS_RST   = 17'd1;
	localparam logic [DATA_W-1:0] FGAM_RST  = 32'd65536;
	localparam logic [DATA_W-1:0] FBET_RST  = 32'd0;
	localparam logic [DEC_W-1:0]  DECAY_RST = 17'd58982;
	localparam logic [DEC_W-1:0]  ONE_Q16   = 17'd65536;

	localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;
	localparam logic [VAR_W-1:0]  VAR_MAX = 31'h7FFF_FFFF;

endpackage

FILE: rtl/core/bnf_ram.sv
// generic single-port ram with registered read
module bnf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/batch_norm_forward_core.sv
// top level of the batch normalization forward core
//
// An item is taken when start is high and busy is low; action, channel and
// the payload fields are sampled at that edge. Load, close and unknown
// actions give no result; accumulate, normalize and read give one result,
// shown on result_value, result_var and saturated for exactly one cycle
// while done is high. The receiver cannot hold a result off.
// Normalize takes 24 square root steps, then 64 divide steps unless the
// standard deviation is zero; close walks every channel, skips those
// without samples and for each other one runs two 64 step divisions on
// the same divide unit, then blends if enabled. A full batch makes an
// accumulate give a saturated result. done rises in the cycle after the
// last busy cycle. The block works on one item at a time; busy stays
// high until it ends. State lives in four single-port rams with
// registered read; accumulator and batch statistic entries carry valid
// flags that reset clears, so no clearing pass is needed. Configuration
// writes through cfg_we, cfg_index and cfg_data take effect at once; the
// user must make them only while the block is idle, which it does not
// enforce. Reset returns configuration and control registers to defaults.
module batch_norm_forward_core #(
	parameter int CHANNELS  = bnf_pkg::CHANNELS_DEF,
	parameter int MAX_BATCH = bnf_pkg::MAX_BATCH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	output logic                                 done,
	input  logic                                 cfg_we,
	input  logic [bnf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bnf_pkg::DATA_W-1:0]           cfg_data,
	input  logic [bnf_pkg::ACT_W-1:0]            action,
	input  logic [bnf_pkg::CH_W-1:0]             channel,
	input  logic signed [bnf_pkg::DATA_W-1:0]    sample,
	input  logic signed [bnf_pkg::DATA_W-1:0]    gamma_in,
	input  logic signed [bnf_pkg::DATA_W-1:0]    beta_in,
	input  logic signed [bnf_pkg::DATA_W-1:0]    mean_in,
	input  logic [bnf_pkg::VAR_W-1:0]            var_in,
	output logic signed [bnf_pkg::DATA_W-1:0]    result_value,
	output logic [bnf_pkg::VAR_W-1:0]            result_var,
	output logic                                 saturated
);

	localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNTW  = $clog2(MAX_BATCH + 1);
	localparam int DVW   = (CNTW > bnf_pkg::SQRT_STEPS) ? CNTW : bnf_pkg::SQRT_STEPS;
	localparam int DW    = bnf_pkg::DATA_W;
	localparam int VW    = bnf_pkg::VAR_W;
	localparam int SW    = bnf_pkg::SUM_W;
	localparam int QW    = bnf_pkg::SQ_W;
	localparam int ACCW  = CNTW + QW + SW;
	localparam int RW    = bnf_pkg::SQRT_STEPS;
	localparam int BLW   = DW + bnf_pkg::DEC_W + 1;
	localparam logic [AW-1:0]   LAST_CH = AW'(CHANNELS - 1);
	localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_BATCH);

	typedef enum logic [19:0] {
		S_IDLE  = 20'h00001,
		S_ACC1  = 20'h00002,
		S_ACC2  = 20'h00004,
		S_RDS   = 20'h00008,
		S_NRD   = 20'h00010,
		S_SQRT  = 20'h00020,
		S_NDIV  = 20'h00040,
		S_NMUL  = 20'h00080,
		S_NOUT  = 20'h00100,
		S_CRD   = 20'h00200,
		S_CCHK  = 20'h00400,
		S_CDIV1 = 20'h00800,
		S_CDIV2 = 20'h01000,
		S_CSQ   = 20'h02000,
		S_CVAR  = 20'h04000,
		S_CBL1  = 20'h08000,
		S_CBL2  = 20'h10000,
		S_CBL3  = 20'h20000,
		S_CBL4  = 20'h40000,
		S_CWR   = 20'h80000
	} state_t;

	state_t state_q;

	// configuration
	logic                        train_q, lock_q, mbu_q;
	logic [bnf_pkg::EPS_W-1:0]   eps_q;
	logic signed [DW-1:0]        fgam_q, fbet_q;
	logic [bnf_pkg::DEC_W-1:0]   decay_q;

	// control
	logic [AW-1:0]            addr_q;
	logic [bnf_pkg::IT_W-1:0] it_q;
	logic                     acc_vld_q [CHANNELS];
	logic                     bat_vld_q [CHANNELS];
	logic                     acc_rv_q, bat_rv_q;
	logic                     done_q;

	// datapath
	logic signed [DW-1:0]   x_q, g_q, b_q, q_q, m_q, om_q, nm_q;
	logic [VW-1:0]          v_q, ov_q;
	logic signed [SW-1:0]   sum_q;
	logic [CNTW-1:0]        cnt_q;
	logic [QW-1:0]          sqo_q, sqp_q, ssq_q, num_q;
	logic signed [QW-1:0]   nprod_q;
	logic [DW:0]            mag_q;
	logic                   neg_q, nz_q, sneg_q, sat_q;
	logic [RW*2-1:0]        rad_q;
	logic [RW-1:0]          root_q;
	logic [RW+2:0]          srem_q;
	logic [DVW-1:0]         rem_q, dvs_q;
	logic signed [BLW-1:0]  bla_q, blb_q;
	logic signed [DW-1:0]   res_v_q;
	logic [VW-1:0]          res_var_q;
	logic                   res_sat_q;

	logic          go, ch_ok, last_ch;
	logic [AW+bnf_pkg::CH_W-1:0] ch_ext;
	logic [AW-1:0] ch_addr, mem_addr;

	logic                     par_we, run_we, bat_we, acc_we;
	logic [2*DW-1:0]          par_wd, par_rd;
	logic [DW+VW-1:0]         run_wd, run_rd, bat_wd, bat_rd;
	logic [ACCW-1:0]          acc_wd, acc_rd;

	logic [CNTW-1:0]        acc_cnt;
	logic [QW-1:0]          acc_sq;
	logic signed [SW-1:0]   acc_sum;
	logic signed [DW-1:0]   run_mean, bat_mean, par_gam, par_bet;
	logic [VW-1:0]          run_var, bat_var;

	// accumulate
	logic signed [SW:0]   acc_s49;
	logic signed [SW-1:0] acc_snew;
	logic                 acc_sov;
	logic [DW-1:0]        xa;
	logic [QW:0]          sq65;
	logic [QW-1:0]        sq_new;

	// normalize
	logic signed [DW-1:0] sel_m, sel_g, sel_b;
	logic [VW-1:0]        sel_v;
	logic signed [DW:0]   diff;
	logic [RW+2:0]        s_t, s_trial, s_rem_nx;
	logic                 s_ge;
	logic [RW-1:0]        root_nx;
	logic [DVW:0]         d_t;
	logic                 d_ge;
	logic [DVW-1:0]       d_rem_nx;
	logic [QW-1:0]        quo_nx;
	logic signed [QW-1:0] n_rnd;
	logic signed [QW-1:0] n_sum;
	logic signed [DW-1:0] n_q_cl;
	logic                 n_q_sat;

	// close
	logic [SW-1:0]        s_mag;
	logic [SW:0]          c_mmag;
	logic signed [SW+1:0] c_msig;
	logic signed [DW-1:0] c_m;
	logic [DW-1:0]        m_abs;
	logic [QW-1:0]        c_dif;
	logic [SW:0]          c_v49;
	logic [bnf_pkg::DEC_W-1:0] dcl, dcm;
	logic signed [BLW:0]  bl_sum;
	logic signed [BLW:0]  bl_rnd;

	logic                 out_fire, out_sat;
	logic signed [DW-1:0] out_val;
	logic [VW-1:0]        out_var;

	assign busy    = (state_q != S_IDLE);
	assign go      = start && !busy;
	assign ch_ok   = (32'(channel) < CHANNELS);
	assign ch_ext  = (AW + bnf_pkg::CH_W)'(channel);
	assign ch_addr = ch_ext[AW-1:0];
	assign mem_addr = busy ? addr_q : ch_addr;
	assign last_ch = (addr_q == LAST_CH);

	// memories
	assign par_we = go && ch_ok && (action == bnf_pkg::ACT_LOAD);
	assign par_wd = {gamma_in, beta_in};
	assign run_we = par_we || (state_q == S_CWR);
	assign run_wd = (state_q == S_CWR) ?
		(mbu_q ? {nm_q, bl_rnd[VW-1:0]} : {m_q, v_q}) : {mean_in, var_in};
	assign bat_we = (state_q == S_CWR);
	assign bat_wd = {m_q, v_q};
	assign acc_we = (state_q == S_ACC2);
	assign acc_wd = {cnt_q, sq_new, sum_q};

	bnf_ram #(.WIDTH(2*DW), .DEPTH(CHANNELS)) u_par (
		.clk(clk), .we(par_we), .addr(mem_addr), .wdata(par_wd), .rdata(par_rd));
	bnf_ram #(.WIDTH(DW+VW), .DEPTH(CHANNELS)) u_run (
		.clk(clk), .we(run_we), .addr(mem_addr), .wdata(run_wd), .rdata(run_rd));
	bnf_ram #(.WIDTH(DW+VW), .DEPTH(CHANNELS)) u_bat (
		.clk(clk), .we(bat_we), .addr(mem_addr), .wdata(bat_wd), .rdata(bat_rd));
	bnf_ram #(.WIDTH(ACCW), .DEPTH(CHANNELS)) u_acc (
		.clk(clk), .we(acc_we), .addr(mem_addr), .wdata(acc_wd), .rdata(acc_rd));

	// invalid entries read as zero
	assign acc_cnt  = acc_rv_q ? acc_rd[ACCW-1 -: CNTW] : '0;
	assign acc_sq   = acc_rv_q ? acc_rd[SW +: QW] : '0;
	assign acc_sum  = acc_rv_q ? $signed(acc_rd[SW-1:0]) : '0;
	assign bat_mean = bat_rv_q ? $signed(bat_rd[DW+VW-1 -: DW]) : '0;
	assign bat_var  = bat_rv_q ? bat_rd[VW-1:0] : '0;
	assign run_mean = $signed(run_rd[DW+VW-1 -: DW]);
	assign run_var  = run_rd[VW-1:0];
	assign par_gam  = $signed(par_rd[2*DW-1 -: DW]);
	assign par_bet  = $signed(par_rd[DW-1:0]);

	always_comb begin
		// accumulate
		acc_s49  = $signed({acc_sum[SW-1], acc_sum}) + (SW+1)'(x_q);
		acc_sov  = (acc_s49[SW] != acc_s49[SW-1]);
		if (acc_sov) begin
			acc_snew = acc_s49[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end else begin
			acc_snew = acc_s49[SW-1:0];
		end
		xa     = x_q[DW-1] ? (~x_q + 1'b1) : x_q;
		sq65   = {1'b0, sqo_q} + {1'b0, sqp_q};
		sq_new = sq65[QW] ? '1 : sq65[QW-1:0];

		// normalize operand select
		sel_m = train_q ? bat_mean : run_mean;
		sel_v = train_q ? bat_var : run_var;
		sel_g = lock_q ? fgam_q : par_gam;
		sel_b = lock_q ? fbet_q : par_bet;
		diff  = (DW+1)'(x_q) - (DW+1)'(sel_m);

		// square root step
		s_t      = {srem_q[RW:0], rad_q[RW*2-1 -: 2]};
		s_trial  = (RW+3)'({root_q, 2'b01});
		s_ge     = (s_t >= s_trial);
		s_rem_nx = s_ge ? (s_t - s_trial) : s_t;
		root_nx  = {root_q[RW-2:0], s_ge};

		// divide step
		d_t      = {rem_q, num_q[QW-1]};
		d_ge     = (d_t >= {1'b0, dvs_q});
		d_rem_nx = d_ge ? DVW'(d_t - {1'b0, dvs_q}) : d_t[DVW-1:0];
		quo_nx   = {num_q[QW-2:0], d_ge};

		// quotient clamp
		n_q_sat = 1'b0;
		if (!neg_q) begin
			if (quo_nx > QW'(bnf_pkg::S32_MAX)) begin
				n_q_cl  = $signed(bnf_pkg::S32_MAX);
				n_q_sat = 1'b1;
			end else begin
				n_q_cl = $signed(quo_nx[DW-1:0]);
			end
		end else begin
			if (quo_nx > QW'(bnf_pkg::S32_MIN)) begin
				n_q_cl  = $signed(bnf_pkg::S32_MIN);
				n_q_sat = 1'b1;
			end else begin
				n_q_cl = $signed(-quo_nx[DW-1:0]);
			end
		end

		n_rnd = (nprod_q + QW'(32768)) >>> 16;
		n_sum = n_rnd + QW'(b_q);

		// close
		s_mag  = acc_sum[SW-1] ? SW'(-acc_sum) : acc_sum;
		c_mmag = (SW+1)'(quo_nx[SW-1:0]) + (SW+1)'(sneg_q && (d_rem_nx != '0));
		c_msig = sneg_q ? -$signed({1'b0, c_mmag}) : $signed({1'b0, c_mmag});
		if (c_msig > (SW+2)'($signed(bnf_pkg::S32_MAX))) begin
			c_m = $signed(bnf_pkg::S32_MAX);
		end else if (c_msig < (SW+2)'($signed(bnf_pkg::S32_MIN))) begin
			c_m = $signed(bnf_pkg::S32_MIN);
		end else begin
			c_m = c_msig[DW-1:0];
		end
		m_abs = m_q[DW-1] ? (~m_q + 1'b1) : m_q;
		c_dif = (ssq_q > sqp_q) ? (ssq_q - sqp_q) : '0;
		c_v49 = (SW+1)'(c_dif[QW-1:16]) + (SW+1)'(eps_q);
		dcl   = (decay_q > bnf_pkg::ONE_Q16) ? bnf_pkg::ONE_Q16 : decay_q;
		dcm   = bnf_pkg::ONE_Q16 - dcl;
		bl_sum = (BLW+1)'(bla_q) + (BLW+1)'(blb_q) + (BLW+1)'(32768);
		bl_rnd = bl_sum >>> 16;

		// result
		out_fire = 1'b0;
		out_val  = '0;
		out_var  = '0;
		out_sat  = 1'b0;
		case (state_q)
			S_ACC1: begin
				if (acc_cnt >= MAX_CNT) begin
					out_fire = 1'b1;
					out_sat  = 1'b1;
				end
			end
			S_ACC2: begin
				out_fire = 1'b1;
				out_sat  = sat_q || sq65[QW];
			end
			S_RDS: begin
				out_fire = 1'b1;
				out_val  = run_mean;
				out_var  = run_var;
			end
			S_NOUT: begin
				out_fire = 1'b1;
				if (n_sum > QW'($signed(bnf_pkg::S32_MAX))) begin
					out_val = $signed(bnf_pkg::S32_MAX);
					out_sat = 1'b1;
				end else if (n_sum < QW'($signed(bnf_pkg::S32_MIN))) begin
					out_val = $signed(bnf_pkg::S32_MIN);
					out_sat = 1'b1;
				end else begin
					out_val = n_sum[DW-1:0];
					out_sat = sat_q;
				end
			end
			default: begin
				out_fire = 1'b0;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			train_q  <= 1'b0;
			lock_q   <= 1'b0;
			mbu_q    <= 1'b0;
			eps_q    <= bnf_pkg::EPS_RST;
			fgam_q   <= $signed(bnf_pkg::FGAM_RST);
			fbet_q   <= $signed(bnf_pkg::FBET_RST);
			decay_q  <= bnf_pkg::DECAY_RST;
			addr_q   <= '0;
			it_q     <= '0;
			acc_rv_q <= 1'b0;
			bat_rv_q <= 1'b0;
			done_q   <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				acc_vld_q[i] <= 1'b0;
				bat_vld_q[i] <= 1'b0;
			end
		end else begin
			done_q   <= out_fire;
			acc_rv_q <= acc_vld_q[mem_addr];
			bat_rv_q <= bat_vld_q[mem_addr];
			if (cfg_we) begin
				case (cfg_index)
					bnf_pkg::REG_TRAIN: train_q <= cfg_data[0];
					bnf_pkg::REG_LOCK:  lock_q  <= cfg_data[0];
					bnf_pkg::REG_MBU:   mbu_q   <= cfg_data[0];
					bnf_pkg::REG_EPS:   eps_q   <= cfg_data[bnf_pkg::EPS_W-1:0];
					bnf_pkg::REG_FGAM:  fgam_q  <= $signed(cfg_data);
					bnf_pkg::REG_FBET:  fbet_q  <= $signed(cfg_data);
					bnf_pkg::REG_DECAY: decay_q <= cfg_data[bnf_pkg::DEC_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					addr_q <= ch_addr;
					if (go && ch_ok) begin
						case (action)
							bnf_pkg::ACT_ACCUM: state_q <= S_ACC1;
							bnf_pkg::ACT_NORM:  state_q <= S_NRD;
							bnf_pkg::ACT_READ:  state_q <= S_RDS;
							bnf_pkg::ACT_CLOSE: begin
								addr_q  <= '0;
								state_q <= S_CRD;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ACC1: state_q <= (acc_cnt >= MAX_CNT) ? S_IDLE : S_ACC2;
				S_ACC2: begin
					acc_vld_q[addr_q] <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RDS: state_q <= S_IDLE;
				S_NRD: begin
					it_q    <= bnf_pkg::IT_W'(bnf_pkg::SQRT_STEPS);
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					it_q <= it_q - 1'b1;
					if (it_q == bnf_pkg::IT_W'(1)) begin
						if (root_nx == '0) begin
							state_q <= S_NMUL;
						end else begin
							it_q    <= bnf_pkg::IT_W'(bnf_pkg::DIV_STEPS);
							state_q <= S_NDIV;
						end
					end
				end
				S_NDIV: begin
					it_q <= it_q - 1'b1;
					if (it_q == bnf_pkg::IT_W'(1)) begin
						state_q <= S_NMUL;
					end
				end
				S_NMUL: state_q <= S_NOUT;
				S_NOUT: state_q <= S_IDLE;
				S_CRD:  state_q <= S_CCHK;
				S_CCHK: begin
					if (acc_cnt == '0) begin
						if (last_ch) begin
							state_q <= S_IDLE;
						end else begin
							addr_q  <= addr_q + 1'b1;
							state_q <= S_CRD;
						end
					end else begin
						it_q    <= bnf_pkg::IT_W'(bnf_pkg::DIV_STEPS);
						state_q <= S_CDIV1;
					end
				end
				S_CDIV1: begin
					it_q <= it_q - 1'b1;
					if (it_q == bnf_pkg::IT_W'(1)) begin
						it_q    <= bnf_pkg::IT_W'(bnf_pkg::DIV_STEPS);
						state_q <= S_CDIV2;
					end
				end
				S_CDIV2: begin
					it_q <= it_q - 1'b1;
					if (it_q == bnf_pkg::IT_W'(1)) begin
						state_q <= S_CSQ;
					end
				end
				S_CSQ:  state_q <= S_CVAR;
				S_CVAR: state_q <= mbu_q ? S_CBL1 : S_CWR;
				S_CBL1: state_q <= S_CBL2;
				S_CBL2: state_q <= S_CBL3;
				S_CBL3: state_q <= S_CBL4;
				S_CBL4: state_q <= S_CWR;
				S_CWR: begin
					acc_vld_q[addr_q] <= 1'b0;
					bat_vld_q[addr_q] <= 1'b1;
					if (last_ch) begin
						state_q <= S_IDLE;
					end else begin
						addr_q  <= addr_q + 1'b1;
						state_q <= S_CRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		res_v_q   <= out_val;
		res_var_q <= out_var;
		res_sat_q <= out_sat;
		case (state_q)
			S_IDLE: begin
				x_q <= sample;
			end
			S_ACC1: begin
				cnt_q <= acc_cnt + 1'b1;
				sum_q <= acc_snew;
				sat_q <= acc_sov;
				sqo_q <= acc_sq;
				sqp_q <= xa * xa;
			end
			S_NRD: begin
				g_q    <= sel_g;
				b_q    <= sel_b;
				neg_q  <= diff[DW];
				nz_q   <= (diff != '0);
				mag_q  <= diff[DW] ? (DW+1)'(-diff) : diff;
				rad_q  <= {1'b0, sel_v, 16'b0};
				root_q <= '0;
				srem_q <= '0;
				sat_q  <= 1'b0;
			end
			S_SQRT: begin
				srem_q <= s_rem_nx;
				root_q <= root_nx;
				rad_q  <= {rad_q[RW*2-3:0], 2'b00};
				if (it_q == bnf_pkg::IT_W'(1)) begin
					q_q   <= !nz_q ? '0 : (neg_q ? $signed(bnf_pkg::S32_MIN) :
						$signed(bnf_pkg::S32_MAX));
					sat_q <= nz_q;
					num_q <= QW'(mag_q) << 16;
					dvs_q <= DVW'(root_nx);
					rem_q <= '0;
				end
			end
			S_NDIV: begin
				num_q <= quo_nx;
				rem_q <= d_rem_nx;
				if (it_q == bnf_pkg::IT_W'(1)) begin
					q_q   <= n_q_cl;
					sat_q <= n_q_sat;
				end
			end
			S_NMUL: begin
				nprod_q <= q_q * g_q;
			end
			S_CCHK: begin
				sneg_q <= acc_sum[SW-1];
				ssq_q  <= acc_sq;
				om_q   <= run_mean;
				ov_q   <= run_var;
				num_q  <= QW'(s_mag);
				dvs_q  <= DVW'(acc_cnt);
				rem_q  <= '0;
			end
			S_CDIV1: begin
				num_q <= quo_nx;
				rem_q <= d_rem_nx;
				if (it_q == bnf_pkg::IT_W'(1)) begin
					m_q   <= c_m;
					num_q <= ssq_q;
					rem_q <= '0;
				end
			end
			S_CDIV2: begin
				num_q <= quo_nx;
				rem_q <= d_rem_nx;
				if (it_q == bnf_pkg::IT_W'(1)) begin
					ssq_q <= quo_nx;
				end
			end
			S_CSQ: begin
				sqp_q <= m_abs * m_abs;
			end
			S_CVAR: begin
				v_q <= (c_v49 > (SW+1)'(bnf_pkg::VAR_MAX)) ? bnf_pkg::VAR_MAX : c_v49[VW-1:0];
			end
			S_CBL1: begin
				bla_q <= $signed({1'b0, dcl}) * om_q;
			end
			S_CBL2: begin
				blb_q <= $signed({1'b0, dcm}) * m_q;
			end
			S_CBL3: begin
				nm_q  <= bl_rnd[DW-1:0];
				bla_q <= $signed({1'b0, dcl}) * $signed({1'b0, ov_q});
			end
			S_CBL4: begin
				blb_q <= $signed({1'b0, dcm}) * $signed({1'b0, v_q});
			end
			default: begin
				x_q <= x_q;
			end
		endcase
	end

	assign done         = done_q;
	assign result_value = res_v_q;
	assign result_var   = res_var_q;
	assign saturated    = res_sat_q;

endmodule
